// ----- sv/krwlt_pkg.sv -----
`timescale 1ns / 1ps

package krwlt_pkg;

  localparam int KEY_W = 64;
  localparam int COUNT_W = 16;

  localparam logic [1:0] MODE_LOCK = 2'd0;
  localparam logic [1:0] MODE_UNLOCK = 2'd1;
  localparam logic [1:0] MODE_FIND = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] lock_key;
    logic             write_request;
    logic             nonblocking;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic               held_for_write;
    logic [COUNT_W-1:0] holders;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE
  } state_t;

endpackage

// ----- sv/krwlt_mem.sv -----
`timescale 1ns / 1ps

module krwlt_mem import krwlt_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int KEY_BITS = 64,
  localparam int IDXW = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDXW-1:0]     wr_addr,
  input  logic                wr_valid,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic                wr_write,
  input  logic [COUNT_W-1:0]  wr_count,
  input  logic [IDXW-1:0]     rd_addr,
  output logic                rd_valid,
  output logic [KEY_BITS-1:0] rd_key,
  output logic                rd_write,
  output logic [COUNT_W-1:0]  rd_count
);

  logic                mem_valid [ENTRIES];
  logic [KEY_BITS-1:0] mem_key   [ENTRIES];
  logic                mem_write [ENTRIES];
  logic [COUNT_W-1:0]  mem_count [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_key[wr_addr]   <= wr_key;
      mem_write[wr_addr] <= wr_write;
      mem_count[wr_addr] <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= mem_valid[rd_addr];
    rd_key   <= mem_key[rd_addr];
    rd_write <= mem_write[rd_addr];
    rd_count <= mem_count[rd_addr];
  end

endmodule

// ----- sv/krwlt_seq.sv -----
`timescale 1ns / 1ps

module krwlt_seq import krwlt_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int KEY_BITS = 64,
  localparam int IDXW = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  req_word_t           req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rsp_word_t           rsp,
  output logic                wr_en,
  output logic [IDXW-1:0]     wr_addr,
  output logic                wr_valid,
  output logic [KEY_BITS-1:0] wr_key,
  output logic                wr_write,
  output logic [COUNT_W-1:0]  wr_count,
  output logic [IDXW-1:0]     rd_addr,
  input  logic                rd_valid,
  input  logic [KEY_BITS-1:0] rd_key,
  input  logic                rd_write,
  input  logic [COUNT_W-1:0]  rd_count
);

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  state_t              state, state_next;
  logic [IDXW-1:0]     idx;
  logic                chk;
  logic [IDXW-1:0]     chk_idx;
  logic [1:0]          mode;
  logic [KEY_BITS-1:0] key;
  logic                wreq;
  logic                nb;
  logic                hit;
  logic [IDXW-1:0]     hit_idx;
  logic                hit_write;
  logic [COUNT_W-1:0]  hit_count;
  logic                free_ok;
  logic [IDXW-1:0]     free_idx;
  logic                accept;
  logic                fire;
  logic                dec_we;
  logic [IDXW-1:0]     dec_addr;
  logic                dec_valid;
  logic                dec_write;
  logic [COUNT_W-1:0]  dec_count;
  rsp_word_t           rsp_next;

  assign req_ready = (state == S_IDLE);
  assign accept = req_valid && req_ready;
  assign fire = (state == S_DECIDE) && (!rsp_valid || rsp_ready);
  assign rd_addr = idx;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE: if (req_valid) state_next = S_SCAN;
      S_SCAN: if (idx == LAST_IDX) state_next = S_LAST;
      S_LAST: state_next = S_DECIDE;
      S_DECIDE: if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    rsp_next = '{status: ST_OK, found: hit, held_for_write: 1'b0, holders: '0};
    dec_we = 1'b0;
    dec_addr = hit_idx;
    dec_valid = 1'b1;
    dec_write = hit_write;
    dec_count = hit_count;
    case (mode)
      MODE_LOCK: begin
        if (!hit) begin
          if (!free_ok) begin
            rsp_next.status = ST_FAIL;
          end else begin
            dec_we = 1'b1;
            dec_addr = free_idx;
            dec_write = wreq;
            dec_count = COUNT_W'(1);
            rsp_next.held_for_write = wreq;
            rsp_next.holders = COUNT_W'(1);
          end
        end else if (wreq || hit_write) begin
          rsp_next.status = nb ? ST_FAIL : ST_WAIT;
          rsp_next.held_for_write = hit_write;
          rsp_next.holders = hit_count;
        end else if (hit_count == COUNT_MAX) begin
          rsp_next.status = ST_FAIL;
          rsp_next.held_for_write = hit_write;
          rsp_next.holders = hit_count;
        end else begin
          dec_we = 1'b1;
          dec_count = hit_count + COUNT_W'(1);
          rsp_next.held_for_write = hit_write;
          rsp_next.holders = dec_count;
        end
      end
      MODE_UNLOCK: begin
        if (!hit) begin
          rsp_next.status = ST_FAIL;
        end else if (hit_count <= COUNT_W'(1)) begin
          dec_we = 1'b1;
          dec_valid = 1'b0;
          dec_count = '0;
        end else begin
          dec_we = 1'b1;
          dec_count = hit_count - COUNT_W'(1);
          rsp_next.held_for_write = hit_write;
          rsp_next.holders = dec_count;
        end
      end
      MODE_FIND: begin
        if (hit) begin
          rsp_next.held_for_write = hit_write;
          rsp_next.holders = hit_count;
        end
      end
      default: begin
        rsp_next.status = ST_FAIL;
        rsp_next.found = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx;
    wr_valid = 1'b0;
    wr_key = key;
    wr_write = dec_write;
    wr_count = dec_count;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (fire) begin
      wr_en = dec_we;
      wr_addr = dec_addr;
      wr_valid = dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      chk <= 1'b0;
      hit <= 1'b0;
      free_ok <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      chk <= (state == S_SCAN);
      if (state inside {S_CLEAR, S_SCAN}) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + IDXW'(1);
      end
      if (accept) begin
        idx <= '0;
        hit <= 1'b0;
        free_ok <= 1'b0;
      end else if (chk) begin
        if (rd_valid && rd_key == key && !hit) hit <= 1'b1;
        if (!rd_valid && !free_ok) free_ok <= 1'b1;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (accept) begin
      mode <= req.mode;
      key <= req.lock_key[KEY_BITS-1:0];
      wreq <= req.write_request;
      nb <= req.nonblocking;
    end
    if (chk && rd_valid && rd_key == key && !hit) begin
      hit_idx <= chk_idx;
      hit_write <= rd_write;
      hit_count <= rd_count;
    end
    if (chk && !rd_valid && !free_ok) begin
      free_idx <= chk_idx;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && !hit && !free_ok)
    else $error("scan did not start cleanly after a request");

  a_no_compare_in_decide: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> !chk)
    else $error("compare still pending while deciding");

  a_rsp_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DECIDE)
    else $error("response raised outside the decide step");

  a_write_with_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && wr_en) |=> rsp_valid)
    else $error("table updated without a response");

endmodule

// ----- sv/keyed_rw_lock_table_top.sv -----
`timescale 1ns / 1ps
// Channel   Handshake               Word
// request   req_valid / req_ready   req  (mode, lock_key, write_request, nonblocking)
// response  rsp_valid / rsp_ready   rsp  (status, found, held_for_write, holders)
//
// Requests are handled one at a time, by one key comparator walking the table
// memory one entry per cycle; a new request is taken only after the last one's
// final update step.
// After reset a clearing pass marks every entry free; req_ready stays low
// until it ends.
// A response waiting on rsp_ready does not block the next request; only the
// final update step waits until the response register is free.

module keyed_rw_lock_table_top import krwlt_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int KEY_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  localparam int IDXW = $clog2(ENTRIES);

  logic                wr_en;
  logic [IDXW-1:0]     wr_addr;
  logic                wr_valid;
  logic [KEY_BITS-1:0] wr_key;
  logic                wr_write;
  logic [COUNT_W-1:0]  wr_count;
  logic [IDXW-1:0]     rd_addr;
  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic                rd_write;
  logic [COUNT_W-1:0]  rd_count;

  krwlt_seq #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_valid (wr_valid),
    .wr_key   (wr_key),
    .wr_write (wr_write),
    .wr_count (wr_count),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_write (rd_write),
    .rd_count (rd_count)
  );

  krwlt_mem #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_valid(wr_valid),
    .wr_key  (wr_key),
    .wr_write(wr_write),
    .wr_count(wr_count),
    .rd_addr (rd_addr),
    .rd_valid(rd_valid),
    .rd_key  (rd_key),
    .rd_write(rd_write),
    .rd_count(rd_count)
  );

endmodule

// ----- bench/lock_table_checker.sv -----
`timescale 1ns / 1ps

module lock_table_checker import krwlt_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int KEY_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  req_word_t req,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  rsp_word_t rsp,
  output int        errors,
  output int        pending,
  output int        checked
);

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  logic               slot_live [ENTRIES];
  logic [KEY_W-1:0]   slot_key  [ENTRIES];
  logic               slot_wr   [ENTRIES];
  logic [COUNT_W-1:0] slot_cnt  [ENTRIES];
  rsp_word_t          awaited [$];
  rsp_word_t          want;

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
  end

  function automatic rsp_word_t lock_outcome(input req_word_t w);
    rsp_word_t r;
    logic [KEY_W-1:0] k;
    int hit;
    int spare;
    r = '0;
    k = w.lock_key & KEY_MASK;
    hit = -1;
    spare = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_key[i] == k) hit = i;
      if (!slot_live[i]) spare = i;
    end
    r.found = (hit >= 0);
    r.status = ST_OK;
    case (w.mode)
      MODE_LOCK: begin
        if (hit < 0) begin
          if (spare < 0) begin
            r.status = ST_FAIL;
          end else begin
            slot_live[spare] = 1'b1;
            slot_key[spare] = k;
            slot_wr[spare] = w.write_request;
            slot_cnt[spare] = COUNT_W'(1);
            hit = spare;
          end
        end else if (w.write_request || slot_wr[hit]) begin
          r.status = w.nonblocking ? ST_FAIL : ST_WAIT;
        end else if (slot_cnt[hit] == COUNT_MAX) begin
          r.status = ST_FAIL;
        end else begin
          slot_cnt[hit] = slot_cnt[hit] + 1'b1;
        end
      end
      MODE_UNLOCK: begin
        if (hit < 0) begin
          r.status = ST_FAIL;
        end else if (slot_cnt[hit] <= 1) begin
          slot_cnt[hit] = '0;
          slot_live[hit] = 1'b0;
          hit = -1;
        end else begin
          slot_cnt[hit] = slot_cnt[hit] - 1'b1;
        end
      end
      MODE_FIND: begin
      end
      default: begin
        r.status = ST_FAIL;
        r.found = 1'b0;
        hit = -1;
      end
    endcase
    if (hit >= 0) begin
      r.held_for_write = slot_wr[hit];
      r.holders = slot_cnt[hit];
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [COUNT_W-1:0] want_v,
                             input logic [COUNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      awaited.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited.size() == 0) begin
          errors++;
          $error("Response word arrived with no request outstanding.");
        end else begin
          want = awaited.pop_front();
          checked++;
          check_field("status", COUNT_W'(want.status), COUNT_W'(rsp.status));
          check_field("found", COUNT_W'(want.found), COUNT_W'(rsp.found));
          check_field("held_for_write", COUNT_W'(want.held_for_write),
                      COUNT_W'(rsp.held_for_write));
          check_field("holders", want.holders, rsp.holders);
        end
      end
      if (req_valid && req_ready) awaited.push_back(lock_outcome(req));
    end
    pending = awaited.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import krwlt_pkg::*;

  localparam int ENTRIES = 64;
  localparam int KEY_BITS = 64;
  localparam int POOL = 12;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  int errors;
  int pending;
  int checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  int climb_words = 0;
  logic [KEY_W-1:0] key_pool [POOL];

  keyed_rw_lock_table_top #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  lock_table_checker #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) watch (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .errors(errors),
    .pending(pending),
    .checked(checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(input logic [1:0] m, input logic [KEY_W-1:0] k,
                           input logic wr, input logic nb);
    req_word_t w;
    w = '{mode: m, lock_key: k, write_request: wr, nonblocking: nb};
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Every third key differs from its neighbor in a single bit.
  task automatic refresh_pool();
    foreach (key_pool[i]) begin
      if (i % 3 == 2) key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(KEY_W - 1));
      else key_pool[i] = {$urandom, $urandom};
    end
  endtask

  task automatic random_burst(input int n);
    logic [KEY_W-1:0] k;
    logic [1:0] m;
    int sel;
    repeat (n) begin
      if ($urandom_range(39) == 0) key_pool[$urandom_range(POOL - 1)] = {$urandom, $urandom};
      if ($urandom_range(19) == 0) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(POOL - 1)];
      sel = $urandom_range(99);
      if (sel < 45) m = MODE_LOCK;
      else if (sel < 75) m = MODE_UNLOCK;
      else if (sel < 94) m = MODE_FIND;
      else m = MODE_UNUSED;
      send_word(m, k, $urandom_range(99) < 30, 1'($urandom_range(1)));
    end
  endtask

  // Overfills the table so the last locks find no free entry, then releases them.
  task automatic fill_table();
    logic [KEY_W-1:0] fresh [ENTRIES + 3];
    foreach (fresh[i]) begin
      fresh[i] = {$urandom, $urandom};
      send_word(MODE_LOCK, fresh[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    foreach (fresh[i]) begin
      send_word(MODE_UNLOCK, fresh[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_fill);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    refresh_pool();
    random_burst(200);
    if (with_fill) fill_table();
  endtask

  // Shared locks pile up on one key, then a writer, a find, an unlock and two more shared locks see the count.
  task automatic climb_holder_count();
    logic [KEY_W-1:0] k;
    int start;
    start = sent;
    k = {$urandom, $urandom};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (30) send_word(MODE_LOCK, k, 1'b0, 1'($urandom_range(1)));
    send_word(MODE_LOCK, k, 1'b0, 1'b0);
    send_word(MODE_LOCK, k, 1'b1, 1'b0);
    send_word(MODE_FIND, k, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, k, 1'b0, 1'b0);
    send_word(MODE_LOCK, k, 1'b0, 1'b1);
    send_word(MODE_LOCK, k, 1'b0, 1'b1);
    climb_words = sent - start;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_word(MODE_FIND, '0, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, '1, 1'b0, 1'b0);
    send_word(MODE_UNUSED, '1, 1'b1, 1'b1);
    send_word(MODE_LOCK, '1, 1'b0, 1'b0);
    send_word(MODE_LOCK, '1, 1'b0, 1'b1);
    send_word(MODE_LOCK, '1, 1'b1, 1'b0);
    send_word(MODE_LOCK, '1, 1'b1, 1'b1);
    send_word(MODE_FIND, '1, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, '1, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, '1, 1'b0, 1'b0);
    send_word(MODE_FIND, '1, 1'b0, 1'b0);
    send_word(MODE_LOCK, '0, 1'b1, 1'b1);
    send_word(MODE_LOCK, '0, 1'b0, 1'b0);
    send_word(MODE_LOCK, '0, 1'b0, 1'b1);
    send_word(MODE_LOCK, '0, 1'b1, 1'b0);
    send_word(MODE_LOCK, {1'b1, 63'd0}, 1'b0, 1'b0);
    send_word(MODE_FIND, 64'd1, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, '0, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, '0, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, {1'b1, 63'd0}, 1'b0, 1'b0);
    send_word(MODE_LOCK, 64'h5555_5555_5555_5555, 1'b0, 1'b1);
    send_word(MODE_LOCK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
    send_word(MODE_UNLOCK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    wait_idle();

    run_phase(0, 0, 1'b1);
    run_phase(80, 0, 1'b0);
    run_phase(0, 80, 1'b0);
    run_phase(27, 27, 1'b1);
    climb_holder_count();

    wait_idle();
    repeat (ENTRIES + 8) @(posedge clk);
    $display("Sent %0d request words and compared %0d responses across four idling phases,",
             sent, checked);
    $display("two table overfills and a %0d-word run of shared locks on one key.",
             climb_words);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
